FILE: rtl/drlw_pkg.sv
// Package: field widths, entry layouts, operation codes and sequencer states for the walk unit.
`default_nettype none
package drlw_pkg;

  localparam int OP_W        = 2;
  localparam int ADDR_W      = 17;
  localparam int LETTER_W    = 5;
  localparam int CHILD_W     = 16;
  localparam int START_W     = 17;
  localparam int COUNT_W     = 20;
  localparam int WORD_ID_W   = 20;
  localparam int EIDX_W      = START_W + 1;
  localparam int SCAN_W      = 5;

  localparam int DEF_EDGE_DEPTH  = 131072;
  localparam int DEF_STATE_DEPTH = 65536;
  localparam int DEF_ID_BITS     = 20;

  localparam logic [LETTER_W-1:0] LETTER_LAST = 5'd25;
  localparam logic [SCAN_W-1:0]   SCAN_LAST   = 5'd25;

  typedef enum logic [OP_W-1:0] {
    OP_EDGE_WR  = 2'd0,
    OP_STATE_WR = 2'd1,
    OP_WALK_RST = 2'd2,
    OP_STEP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STATE,
    S_SCAN
  } walk_fsm_t;

  typedef struct packed {
    logic                end_of_list;
    logic                end_of_word;
    logic [CHILD_W-1:0]  child;
    logic [LETTER_W-1:0] letter;
  } edge_t;

  typedef struct packed {
    logic               has_edges;
    logic [COUNT_W-1:0] word_count;
    logic [START_W-1:0] edge_start;
  } state_t;

  localparam int EDGE_W  = $bits(edge_t);
  localparam int STATE_W = $bits(state_t);

endpackage
`default_nettype wire

FILE: rtl/dawg_ranked_letter_walk_unit.sv
// Top level: root register, edge and state RAMs, and the walk sequencer.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------
//   input    | start, busy (take: !busy)  | in_operation .. in_letter
//   result   | out_valid, one cycle       | out_is_word, out_word_id, out_live
//   config   | cfg_we                     | cfg_wdata (root_state)
//
// Writes and walk resets give their result the cycle after the transfer; busy stays low.
// A step reads the current state, then scans its edge list one edge at a time (at most 26),
// each edge RAM read overlapped with the child state read.
// A step on a dead walk answers the next cycle. Reset clears the walk to not live, root 0;
// table contents are undefined until written and need no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module dawg_ranked_letter_walk_unit
  import drlw_pkg::*;
#(
  parameter int EDGE_DEPTH  = DEF_EDGE_DEPTH,
  parameter int STATE_DEPTH = DEF_STATE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OP_W-1:0]       in_operation,
  input  wire logic [ADDR_W-1:0]     in_address,
  input  wire logic [LETTER_W-1:0]   in_edge_letter,
  input  wire logic [CHILD_W-1:0]    in_edge_child,
  input  wire logic                  in_edge_end_of_word,
  input  wire logic                  in_edge_end_of_list,
  input  wire logic [START_W-1:0]    in_state_edge_start,
  input  wire logic [COUNT_W-1:0]    in_state_word_count,
  input  wire logic                  in_state_has_edges,
  input  wire logic [LETTER_W-1:0]   in_letter,
  output logic                       out_valid,
  output logic                       out_is_word,
  output logic [WORD_ID_W-1:0]       out_word_id,
  output logic                       out_live,
  input  wire logic                  cfg_we,
  input  wire logic [CHILD_W-1:0]    cfg_wdata
);

  localparam int EA_W = $clog2(EDGE_DEPTH);
  localparam int SA_W = $clog2(STATE_DEPTH);

  logic [CHILD_W-1:0] root_state_r;
  logic               e_we, e_re, s_we, s_re;
  logic [EA_W-1:0]    e_waddr, e_raddr;
  logic [SA_W-1:0]    s_waddr, s_raddr;
  logic [EDGE_W-1:0]  e_wdata, e_rdata;
  logic [STATE_W-1:0] s_wdata, s_rdata;
  logic [ID_BITS-1:0] out_id;
  logic [31:0]        out_id32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_state_r <= '0;
    end else if (cfg_we) begin
      root_state_r <= cfg_wdata;
    end
  end

  drlw_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  drlw_ram #(
    .WIDTH (STATE_W),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  drlw_walk_ctrl #(
    .EDGE_DEPTH  (EDGE_DEPTH),
    .STATE_DEPTH (STATE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_walk_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_address          (in_address),
    .in_edge_letter      (in_edge_letter),
    .in_edge_child       (in_edge_child),
    .in_edge_end_of_word (in_edge_end_of_word),
    .in_edge_end_of_list (in_edge_end_of_list),
    .in_state_edge_start (in_state_edge_start),
    .in_state_word_count (in_state_word_count),
    .in_state_has_edges  (in_state_has_edges),
    .in_letter           (in_letter),
    .root_state          (root_state_r),
    .e_we                (e_we),
    .e_waddr             (e_waddr),
    .e_wdata             (e_wdata),
    .e_re                (e_re),
    .e_raddr             (e_raddr),
    .e_rdata             (e_rdata),
    .s_we                (s_we),
    .s_waddr             (s_waddr),
    .s_wdata             (s_wdata),
    .s_re                (s_re),
    .s_raddr             (s_raddr),
    .s_rdata             (s_rdata),
    .out_valid           (out_valid),
    .out_is_word         (out_is_word),
    .out_id              (out_id),
    .out_live            (out_live)
  );

  assign out_id32    = 32'(out_id);
  assign out_word_id = out_id32[WORD_ID_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/drlw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module drlw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/drlw_walk_ctrl.sv
// Walk sequencer: table writes, walk reset and the edge-list scan over the two RAMs.
`default_nettype none
module drlw_walk_ctrl
  import drlw_pkg::*;
#(
  parameter int EDGE_DEPTH  = DEF_EDGE_DEPTH,
  parameter int STATE_DEPTH = DEF_STATE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [OP_W-1:0]                in_operation,
  input  wire logic [ADDR_W-1:0]              in_address,
  input  wire logic [LETTER_W-1:0]            in_edge_letter,
  input  wire logic [CHILD_W-1:0]             in_edge_child,
  input  wire logic                           in_edge_end_of_word,
  input  wire logic                           in_edge_end_of_list,
  input  wire logic [START_W-1:0]             in_state_edge_start,
  input  wire logic [COUNT_W-1:0]             in_state_word_count,
  input  wire logic                           in_state_has_edges,
  input  wire logic [LETTER_W-1:0]            in_letter,
  input  wire logic [CHILD_W-1:0]             root_state,
  output logic                                e_we,
  output logic [$clog2(EDGE_DEPTH)-1:0]       e_waddr,
  output logic [EDGE_W-1:0]                   e_wdata,
  output logic                                e_re,
  output logic [$clog2(EDGE_DEPTH)-1:0]       e_raddr,
  input  wire logic [EDGE_W-1:0]              e_rdata,
  output logic                                s_we,
  output logic [$clog2(STATE_DEPTH)-1:0]      s_waddr,
  output logic [STATE_W-1:0]                  s_wdata,
  output logic                                s_re,
  output logic [$clog2(STATE_DEPTH)-1:0]      s_raddr,
  input  wire logic [STATE_W-1:0]             s_rdata,
  output logic                                out_valid,
  output logic                                out_is_word,
  output logic [ID_BITS-1:0]                  out_id,
  output logic                                out_live
);

  localparam int EA_W = $clog2(EDGE_DEPTH);
  localparam int SA_W = $clog2(STATE_DEPTH);

  walk_fsm_t           fsm_r, fsm_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  logic [EIDX_W-1:0]   edge_idx_r, edge_idx_nxt;
  logic [SCAN_W-1:0]   scan_n_r, scan_n_nxt;
  logic [ID_BITS-1:0]  base_r, base_nxt;
  logic                prev_eow_r, prev_eow_nxt;
  logic                have_child_r, have_child_nxt;
  logic                s_oob_r, s_oob_nxt;
  logic [CHILD_W-1:0]  cur_state_r, cur_state_nxt;
  logic [ID_BITS-1:0]  rank_r, rank_nxt;
  logic                live_r, live_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_is_word_r, out_is_word_nxt;
  logic [ID_BITS-1:0]  out_id_r, out_id_nxt;
  logic                out_live_r, out_live_nxt;

  logic                accept;
  op_t                 op;
  edge_t               e;
  edge_t               e_new;
  state_t              st;
  state_t              st_new;
  logic [31:0]         in_addr32, cur32, child32, start32, eidx_next32, cnt32;
  logic [EIDX_W-1:0]   idx_next;
  logic [ID_BITS-1:0]  cnt_rank;
  logic [ID_BITS-1:0]  base_eff;
  logic                letter_hit;

  assign accept     = start && (fsm_r == S_IDLE);
  assign busy       = (fsm_r != S_IDLE);
  assign op         = op_t'(in_operation);
  assign e          = edge_t'(e_rdata);
  assign st         = s_oob_r ? '0 : state_t'(s_rdata);
  assign idx_next   = edge_idx_r + EIDX_W'(1);
  assign in_addr32  = 32'(in_address);
  assign cur32      = 32'(cur_state_r);
  assign child32    = 32'(e.child);
  assign start32    = 32'(st.edge_start);
  assign eidx_next32 = 32'(idx_next);
  assign cnt32      = 32'(st.word_count);
  assign cnt_rank   = cnt32[ID_BITS-1:0];
  assign base_eff   = have_child_r ? (base_r + ID_BITS'(prev_eow_r) + cnt_rank) : base_r;
  assign letter_hit = (letter_r <= LETTER_LAST) && (e.letter == letter_r);

  always_comb begin
    e_new.end_of_list = in_edge_end_of_list;
    e_new.end_of_word = in_edge_end_of_word;
    e_new.child       = in_edge_child;
    e_new.letter      = in_edge_letter;
    st_new.has_edges  = in_state_has_edges;
    st_new.word_count = in_state_word_count;
    st_new.edge_start = in_state_edge_start;
  end

  assign e_waddr = in_addr32[EA_W-1:0];
  assign e_wdata = e_new;
  assign s_waddr = in_addr32[SA_W-1:0];
  assign s_wdata = st_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      cur_state_r <= '0;
      rank_r      <= '0;
      live_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      cur_state_r <= cur_state_nxt;
      rank_r      <= rank_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    letter_r      <= letter_nxt;
    edge_idx_r    <= edge_idx_nxt;
    scan_n_r      <= scan_n_nxt;
    base_r        <= base_nxt;
    prev_eow_r    <= prev_eow_nxt;
    have_child_r  <= have_child_nxt;
    s_oob_r       <= s_oob_nxt;
    out_is_word_r <= out_is_word_nxt;
    out_id_r      <= out_id_nxt;
    out_live_r    <= out_live_nxt;
  end

  always_comb begin
    fsm_nxt         = fsm_r;
    letter_nxt      = letter_r;
    edge_idx_nxt    = edge_idx_r;
    scan_n_nxt      = scan_n_r;
    base_nxt        = base_r;
    prev_eow_nxt    = prev_eow_r;
    have_child_nxt  = have_child_r;
    s_oob_nxt       = s_oob_r;
    cur_state_nxt   = cur_state_r;
    rank_nxt        = rank_r;
    live_nxt        = live_r;
    out_valid_nxt   = 1'b0;
    out_is_word_nxt = out_is_word_r;
    out_id_nxt      = out_id_r;
    out_live_nxt    = out_live_r;
    e_we            = 1'b0;
    e_re            = 1'b0;
    e_raddr         = start32[EA_W-1:0];
    s_we            = 1'b0;
    s_re            = 1'b0;
    s_raddr         = cur32[SA_W-1:0];

    case (fsm_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_EDGE_WR: begin
              e_we            = (in_addr32 < 32'(EDGE_DEPTH));
              out_valid_nxt   = 1'b1;
              out_is_word_nxt = 1'b0;
              out_id_nxt      = '0;
              out_live_nxt    = live_r;
            end
            OP_STATE_WR: begin
              s_we            = (in_addr32 < 32'(STATE_DEPTH));
              out_valid_nxt   = 1'b1;
              out_is_word_nxt = 1'b0;
              out_id_nxt      = '0;
              out_live_nxt    = live_r;
            end
            OP_WALK_RST: begin
              cur_state_nxt   = root_state;
              rank_nxt        = '0;
              live_nxt        = 1'b1;
              out_valid_nxt   = 1'b1;
              out_is_word_nxt = 1'b0;
              out_id_nxt      = '0;
              out_live_nxt    = 1'b1;
            end
            OP_STEP: begin
              if (!live_r) begin
                out_valid_nxt   = 1'b1;
                out_is_word_nxt = 1'b0;
                out_id_nxt      = '0;
                out_live_nxt    = 1'b0;
              end else begin
                s_re       = (cur32 < 32'(STATE_DEPTH));
                s_oob_nxt  = !(cur32 < 32'(STATE_DEPTH));
                letter_nxt = in_letter;
                fsm_nxt    = S_STATE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_STATE: begin
        if (!st.has_edges || !(start32 < 32'(EDGE_DEPTH))) begin
          live_nxt        = 1'b0;
          out_valid_nxt   = 1'b1;
          out_is_word_nxt = 1'b0;
          out_id_nxt      = '0;
          out_live_nxt    = 1'b0;
          fsm_nxt         = S_IDLE;
        end else begin
          e_re           = 1'b1;
          e_raddr        = start32[EA_W-1:0];
          edge_idx_nxt   = {1'b0, st.edge_start};
          scan_n_nxt     = '0;
          base_nxt       = rank_r;
          have_child_nxt = 1'b0;
          fsm_nxt        = S_SCAN;
        end
      end

      S_SCAN: begin
        if (letter_hit) begin
          cur_state_nxt   = e.child;
          rank_nxt        = base_eff + ID_BITS'(e.end_of_word);
          out_valid_nxt   = 1'b1;
          out_is_word_nxt = e.end_of_word;
          out_id_nxt      = e.end_of_word ? base_eff : '0;
          out_live_nxt    = 1'b1;
          fsm_nxt         = S_IDLE;
        end else if (e.end_of_list || (scan_n_r == SCAN_LAST) ||
                     !(eidx_next32 < 32'(EDGE_DEPTH))) begin
          live_nxt        = 1'b0;
          out_valid_nxt   = 1'b1;
          out_is_word_nxt = 1'b0;
          out_id_nxt      = '0;
          out_live_nxt    = 1'b0;
          fsm_nxt         = S_IDLE;
        end else begin
          base_nxt       = base_eff;
          prev_eow_nxt   = e.end_of_word;
          have_child_nxt = 1'b1;
          s_re           = (child32 < 32'(STATE_DEPTH));
          s_oob_nxt      = !(child32 < 32'(STATE_DEPTH));
          s_raddr        = child32[SA_W-1:0];
          e_re           = 1'b1;
          e_raddr        = eidx_next32[EA_W-1:0];
          edge_idx_nxt   = idx_next;
          scan_n_nxt     = scan_n_r + SCAN_W'(1);
        end
      end

      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_is_word = out_is_word_r;
  assign out_id      = out_id_r;
  assign out_live    = out_live_r;

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid_r)
    else $error("walk finished without a result transfer");

  a_word_is_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_word_r) |-> out_live_r)
    else $error("word reported on a dead walk");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_word_r) |-> (out_id_r == '0))
    else $error("nonzero word id without a word");

  a_dead_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == OP_STEP) && !live_r) |=> (out_valid_r && !out_live_r && !busy))
    else $error("step on a dead walk not answered at once");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_SCAN) |-> (scan_n_r <= SCAN_LAST))
    else $error("edge scan ran past its limit");

endmodule
`default_nettype wire
